### design/rc4_pkg.sv
package rc4_pkg;

   localparam int TABLE_SIZE = 256;
   localparam int IDX_W      = $clog2(TABLE_SIZE);

   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_FILL  = 9'b000000010,
      ST_SH_RD = 9'b000000100,
      ST_SH_RJ = 9'b000001000,
      ST_SH_W1 = 9'b000010000,
      ST_SH_W2 = 9'b000100000,
      ST_D_RJ  = 9'b001000000,
      ST_D_SW  = 9'b010000000,
      ST_D_OUT = 9'b100000000
   } state_type;

endpackage

### design/rc4_ram.sv
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/rc4_stream_cipher.sv
// Data word: accepted while idle, then read-j, swap and output steps; the result is
// registered at the end of the output step, which waits while a held result stalls it.
// No new word is taken until then. Key word: stored in the key RAM while it has room.
// The last key word adds the key schedule in the table RAM: a refill with identity,
// then 256 swap steps, each reading S[i], then S[j], then writing both. The order
// follows from that RAM's single read and single write port. Reset: synchronous;
module rc4_stream_cipher #(
   parameter int KEY_MAX_BYTES = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_type,
   input  logic [7:0] req_data_byte,
   input  logic       req_key_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_cipher_byte
);
   import rc4_pkg::*;

   // then the refill runs, taking no word. Indices and key count clear to zero.
   localparam int KIDX_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
   localparam int CNT_W  = $clog2(KEY_MAX_BYTES + 1);
   localparam logic [CNT_W-1:0] KEY_MAX = CNT_W'(KEY_MAX_BYTES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);

   state_type         state_ff, state_in;
   logic              sched_ff, sched_in;
   logic [IDX_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  jj_ff, jj_in;
   logic [KIDX_W-1:0] kidx_ff, kidx_in;
   logic [CNT_W-1:0]  key_count_ff, key_count_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [7:0]        sv_ff, sv_in;
   logic [7:0]        b_ff, b_in;
   logic [7:0]        byte_ff, byte_in;
   logic              hit_i_ff, hit_i_in;
   logic              hit_j_ff, hit_j_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;

   logic              perm_we;
   logic [IDX_W-1:0]  perm_wr_addr;
   logic [7:0]        perm_wr_data;
   logic [IDX_W-1:0]  perm_rd_addr;
   logic [7:0]        perm_rd_data;
   logic              key_we;
   logic [7:0]        key_rd_data;

   logic              req_accept;
   logic              key_store_ok;
   logic [CNT_W-1:0]  count_next;
   logic [CNT_W-1:0]  kidx_inc;
   logic [IDX_W-1:0]  sum_t;
   logic [7:0]        key_sel;

   rc4_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_perm_ram (
      .clock   (clock),
      .wr_en   (perm_we),
      .wr_addr (perm_wr_addr),
      .wr_data (perm_wr_data),
      .rd_addr (perm_rd_addr),
      .rd_data (perm_rd_data)
   );

   rc4_ram #(.WIDTH(8), .DEPTH(KEY_MAX_BYTES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_count_ff[KIDX_W-1:0]),
      .wr_data (req_data_byte),
      .rd_addr (kidx_ff),
      .rd_data (key_rd_data)
   );

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign key_store_ok = (key_count_ff < KEY_MAX);
   assign key_we       = req_accept && (req_type == REQ_KEY) && key_store_ok;
   assign count_next   = key_count_ff + CNT_W'(key_store_ok);
   assign kidx_inc     = CNT_W'(kidx_ff) + CNT_W'(1);
   assign sum_t        = sv_ff + perm_rd_data;
   assign key_sel      = (rsp_valid_ff && rsp_stall) ? rsp_byte_ff : byte_ff;

   // table RAM port muxing
   always_comb begin
      perm_we      = 1'b0;
      perm_wr_addr = n_ff;
      perm_wr_data = perm_rd_data;
      perm_rd_addr = n_ff;
      case (state_ff)
         ST_IDLE:  perm_rd_addr = i_ff + IDX_W'(1);
         ST_FILL: begin
            perm_we      = 1'b1;
            perm_wr_data = n_ff;
         end
         ST_SH_RD: perm_rd_addr = n_ff;
         ST_SH_RJ: perm_rd_addr = jj_ff + perm_rd_data + key_rd_data;
         ST_SH_W1: perm_we = 1'b1;
         ST_SH_W2: begin
            perm_we      = 1'b1;
            perm_wr_addr = jj_ff;
            perm_wr_data = sv_ff;
         end
         ST_D_RJ:  perm_rd_addr = j_ff + perm_rd_data;
         ST_D_SW: begin
            perm_we      = 1'b1;
            perm_wr_addr = i_ff;
            perm_rd_addr = sum_t;
         end
         ST_D_OUT: begin
            perm_we      = 1'b1;
            perm_wr_addr = j_ff;
            perm_wr_data = sv_ff;
            perm_rd_addr = sv_ff + b_ff;
         end
         default: perm_we = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      sched_in     = sched_ff;
      n_in         = n_ff;
      jj_in        = jj_ff;
      kidx_in      = kidx_ff;
      key_count_in = key_count_ff;
      len_in       = len_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      sv_in        = sv_ff;
      b_in         = b_ff;
      byte_in      = byte_ff;
      hit_i_in     = hit_i_ff;
      hit_j_in     = hit_j_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = key_sel;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_type == REQ_DATA) begin
                  i_in     = i_ff + IDX_W'(1);
                  byte_in  = req_data_byte;
                  state_in = ST_D_RJ;
               end else if (req_key_last) begin
                  len_in       = count_next;
                  key_count_in = '0;
                  sched_in     = 1'b1;
                  n_in         = '0;
                  state_in     = ST_FILL;
               end else begin
                  key_count_in = count_next;
               end
            end
         end
         ST_FILL: begin
            n_in = n_ff + IDX_W'(1);
            if (n_ff == IDX_LAST) begin
               jj_in    = '0;
               kidx_in  = '0;
               state_in = sched_ff ? ST_SH_RD : ST_IDLE;
            end
         end
         ST_SH_RD: state_in = ST_SH_RJ;
         ST_SH_RJ: begin
            sv_in    = perm_rd_data;
            jj_in    = jj_ff + perm_rd_data + key_rd_data;
            kidx_in  = (kidx_inc == len_ff) ? '0 : kidx_inc[KIDX_W-1:0];
            state_in = ST_SH_W1;
         end
         ST_SH_W1: state_in = ST_SH_W2;
         ST_SH_W2: begin
            n_in = n_ff + IDX_W'(1);
            if (n_ff == IDX_LAST) begin
               i_in     = '0;
               j_in     = '0;
               sched_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SH_RD;
            end
         end
         ST_D_RJ: begin
            sv_in    = perm_rd_data;
            j_in     = j_ff + perm_rd_data;
            state_in = ST_D_SW;
         end
         ST_D_SW: begin
            // swap lands after this read: forward the swapped values
            b_in     = perm_rd_data;
            hit_j_in = (sum_t == j_ff);
            hit_i_in = (sum_t == i_ff);
            state_in = ST_D_OUT;
         end
         ST_D_OUT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = byte_ff ^ (hit_j_ff ? sv_ff :
                                         hit_i_ff ? b_ff : perm_rd_data);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         sched_ff     <= 1'b0;
         n_ff         <= '0;
         key_count_ff <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sched_ff     <= sched_in;
         n_ff         <= n_in;
         key_count_ff <= key_count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      jj_ff       <= jj_in;
      kidx_ff     <= kidx_in;
      len_ff      <= len_in;
      sv_ff       <= sv_in;
      b_ff        <= b_in;
      byte_ff     <= byte_in;
      hit_i_ff    <= hit_i_in;
      hit_j_ff    <= hit_j_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cipher_byte = rsp_byte_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_D_OUT))
      else $error("result loaded outside output step");

   a_sched_clears_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SH_W2 && n_ff == IDX_LAST) |=> (i_ff == '0 && j_ff == '0))
      else $error("indices not cleared after key schedule");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !perm_we)
      else $error("table written while idle");

endmodule
